@@ design/pie_pkg.sv @@
// pie_pkg: shared types, constants and helpers for the price indicator engine
// depends on nothing; imported by price_indicator_engine and pie_div
package pie_pkg;

  localparam int PriceW = 32;
  localparam int AvgW   = 48;
  localparam int DivNW  = 64;
  localparam int DivDW  = 49;
  localparam int CountW = 16;
  localparam int RsiW   = 17;
  localparam int CfgW   = 7;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_MOM_LAG = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SMA_LEN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RSI_PER = 2'd2;

  localparam logic [RsiW-1:0] RSI_HALF = 17'd32768;
  localparam logic [RsiW-1:0] RSI_ONE  = 17'd65536;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLOSE, ST_GSET, ST_GWAIT, ST_LSET, ST_LWAIT, ST_COMMIT,
    ST_RES, ST_MRD, ST_MDAT, ST_MWAIT, ST_SBEG, ST_SRD, ST_SACC, ST_SDIV,
    ST_SWAIT, ST_RSI, ST_RWAIT, ST_EMIT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] num;
    logic [DivDW-1:0] den;
  } div_req_t;

  // signed q16 result from sign and magnitude quotient, saturated to 32 bits
  function automatic logic [31:0] sat_q16(input logic neg, input logic [DivNW-1:0] q);
    logic [DivNW-1:0] neg_q;
    neg_q = DivNW'(0) - q;
    if (neg) begin
      if (q > DivNW'(64'h8000_0000)) return 32'h8000_0000;
      return neg_q[31:0];
    end
    if (q > DivNW'(64'h7FFF_FFFF)) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

endpackage

@@ design/price_indicator_engine.sv @@
// price_indicator_engine: momentum, wilder rsi and sma distance over a close series
// depends on pie_pkg, pie_ram and pie_div
//
// usage
//   input channel: one close per beat (close_price_i, price_missing_i,
//   series_end_i), taken when in_valid_i is high and in_stall_o is low.
//   a missing close repeats the previous close; missing closes before the
//   first real close of a series are dropped.
//   output channel: one result beat per series_end beat, held while
//   out_stall_i is high; the next input beat is taken meanwhile.
//   config: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 momentum lag, 1 sma length, 2 rsi period); write only when idle.
// work per item
//   a close adds the two divisions by the period (gain and loss) once rsi
//   averaging needs them; every division goes through the one shared
//   serial divider.
//   a series_end beat adds up to 3 divisions (momentum, sma distance, rsi)
//   and one ring read per averaged close for the sma sum.
//   in_stall_o is high for the whole time an item is worked on.
// reset
//   clears the series state and sets the registers to lag 30, length 50,
//   period 14; no ring clearing pass is needed since only entries written
//   in the current series are ever used.
module price_indicator_engine #(
  parameter int RING_DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pie_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pie_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [31:0]                  close_price_i,
  input  logic                         price_missing_i,
  input  logic                         series_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           momentum_o,
  output logic [16:0]                  rsi_fraction_o,
  output logic signed [31:0]           sma_distance_o
);
  import pie_pkg::*;

  localparam int PtrW = $clog2(RING_DEPTH);
  localparam int LenW = $clog2(RING_DEPTH + 1);
  localparam int SumW = PriceW + PtrW + 1;

  // registers
  logic [5:0]        lag_cfg_q;
  logic [6:0]        len_cfg_q;
  logic [5:0]        per_cfg_q;

  // series state
  state_e            state_q, state_d;
  logic [PtrW-1:0]   ptr_q, ptr_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [AvgW-1:0]   ag_q, ag_d, al_q, al_d;
  logic [PriceW-1:0] prev_q, prev_d;

  // item in flight
  logic [PriceW-1:0] c_q, c_d;
  logic              do_close_q, do_close_d;
  logic              last_q, last_d;
  logic              seed_q, seed_d;
  logic              neg_q, neg_d;
  logic [PtrW-1:0]   k_q, k_d;
  logic [SumW-1:0]   sum_q, sum_d;

  // results
  logic [31:0]       mom_q, mom_d, dist_q, dist_d;
  logic [RsiW-1:0]   rsi_q, rsi_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       mom_out_q, mom_out_d, dist_out_q, dist_out_d;
  logic [RsiW-1:0]   rsi_out_q, rsi_out_d;

  // shared units
  div_req_t          div_req;
  logic              div_done;
  logic [DivNW-1:0]  div_quot;
  logic              ram_we;
  logic [PtrW-1:0]   ram_raddr;
  logic [PriceW-1:0] ram_rdata;

  // effective configuration
  logic [5:0]        per_eff;
  logic [PtrW-1:0]   lag_eff;
  logic [LenW-1:0]   len_eff;
  logic [PriceW-1:0] gain, loss, chg;
  logic [AvgW-1:0]   avg_sel;
  logic [AvgW+5:0]   avg_mul;
  logic [SumW-1:0]   scaled;

  assign per_eff = (per_cfg_q < 6'd2) ? 6'd2 : per_cfg_q;
  assign lag_eff = (int'(lag_cfg_q) > RING_DEPTH - 1) ? PtrW'(RING_DEPTH - 1)
                                                      : PtrW'(lag_cfg_q);
  assign len_eff = (len_cfg_q == 7'd0) ? LenW'(1) :
                   (int'(len_cfg_q) > RING_DEPTH) ? LenW'(RING_DEPTH) : LenW'(len_cfg_q);

  assign gain = (c_q > prev_q) ? c_q - prev_q : '0;
  assign loss = (c_q > prev_q) ? '0 : prev_q - c_q;
  assign scaled = SumW'(prev_q) * SumW'(len_eff);

  // ring slot that lies k closes behind the newest
  function automatic logic [PtrW-1:0] back_addr(input logic [PtrW-1:0] ptr,
                                                input logic [PtrW-1:0] k);
    logic [PtrW:0] a;
    a = (PtrW+1)'(ptr) + (PtrW+1)'(RING_DEPTH - 1) - (PtrW+1)'(k);
    if (int'(a) >= RING_DEPTH) a = a - (PtrW+1)'(RING_DEPTH);
    return a[PtrW-1:0];
  endfunction

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    ag_d        = ag_q;
    al_d        = al_q;
    prev_d      = prev_q;
    c_d         = c_q;
    do_close_d  = do_close_q;
    last_d      = last_q;
    seed_d      = seed_q;
    neg_d       = neg_q;
    k_d         = k_q;
    sum_d       = sum_q;
    mom_d       = mom_q;
    rsi_d       = rsi_q;
    dist_d      = dist_q;
    mom_out_d   = mom_out_q;
    rsi_out_d   = rsi_out_q;
    dist_out_d  = dist_out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_req     = '0;
    ram_we      = 1'b0;
    ram_raddr   = back_addr(ptr_q, '0);
    chg         = '0;
    avg_sel     = '0;
    avg_mul     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          c_d        = price_missing_i ? prev_q : close_price_i;
          do_close_d = !price_missing_i || (cnt_q != '0);
          last_d     = series_end_i;
          state_d    = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        seed_d = 1'b0;
        if (!do_close_q) begin
          state_d = last_q ? ST_RES : ST_IDLE;
        end else if (cnt_q == '0) begin
          state_d = ST_COMMIT;
        end else if (cnt_q <= CountW'(per_eff)) begin
          ag_d = ag_q + AvgW'(gain);
          al_d = al_q + AvgW'(loss);
          seed_d = 1'b1;
          state_d = (cnt_q == CountW'(per_eff)) ? ST_GSET : ST_COMMIT;
        end else begin
          state_d = ST_GSET;
        end
      end
      ST_GSET, ST_LSET: begin
        // seed: sum*2^16/p; smoothing: (avg*(p-1) + x*2^16)/p
        avg_sel = (state_q == ST_GSET) ? ag_q : al_q;
        chg     = (state_q == ST_GSET) ? gain : loss;
        avg_mul = (AvgW+6)'(avg_sel) * (AvgW+6)'(per_eff - 6'd1);
        div_req.start = 1'b1;
        div_req.den   = DivDW'(per_eff);
        if (seed_q) begin
          div_req.num = {avg_sel, 16'h0000};
        end else begin
          div_req.num = DivNW'(avg_mul) + DivNW'({chg, 16'h0000});
        end
        state_d = (state_q == ST_GSET) ? ST_GWAIT : ST_LWAIT;
      end
      ST_GWAIT: begin
        if (div_done) begin
          ag_d    = div_quot[AvgW-1:0];
          state_d = ST_LSET;
        end
      end
      ST_LWAIT: begin
        if (div_done) begin
          al_d    = div_quot[AvgW-1:0];
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        ram_we  = 1'b1;
        ptr_d   = (int'(ptr_q) == RING_DEPTH - 1) ? '0 : ptr_q + 1'b1;
        if (cnt_q != '1) cnt_d = cnt_q + 1'b1;
        prev_d  = c_q;
        state_d = last_q ? ST_RES : ST_IDLE;
      end
      ST_RES: begin
        mom_d   = '0;
        rsi_d   = RSI_HALF;
        dist_d  = '0;
        state_d = (cnt_q == '0) ? ST_EMIT : ST_MRD;
      end
      ST_MRD: begin
        ram_raddr = back_addr(ptr_q, lag_eff);
        state_d   = ST_MDAT;
      end
      ST_MDAT: begin
        if ((cnt_q > CountW'(lag_eff)) && (ram_rdata != '0)) begin
          neg_d = prev_q < ram_rdata;
          div_req.start = 1'b1;
          div_req.num = (prev_q < ram_rdata) ? DivNW'({ram_rdata - prev_q, 16'h0000})
                                             : DivNW'({prev_q - ram_rdata, 16'h0000});
          div_req.den = DivDW'(ram_rdata);
          state_d = ST_MWAIT;
        end else begin
          state_d = ST_SBEG;
        end
      end
      ST_MWAIT: begin
        if (div_done) begin
          mom_d   = sat_q16(neg_q, div_quot);
          state_d = ST_SBEG;
        end
      end
      ST_SBEG: begin
        k_d     = '0;
        sum_d   = '0;
        state_d = (cnt_q >= CountW'(len_eff)) ? ST_SRD : ST_RSI;
      end
      ST_SRD: begin
        ram_raddr = back_addr(ptr_q, k_q);
        state_d   = ST_SACC;
      end
      ST_SACC: begin
        sum_d = sum_q + SumW'(ram_rdata);
        if (LenW'(k_q) == len_eff - 1'b1) begin
          state_d = ST_SDIV;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_SRD;
        end
      end
      ST_SDIV: begin
        if (sum_q != '0) begin
          neg_d = scaled < sum_q;
          div_req.start = 1'b1;
          div_req.num = (scaled < sum_q) ? DivNW'({sum_q - scaled, 16'h0000})
                                         : DivNW'({scaled - sum_q, 16'h0000});
          div_req.den = DivDW'(sum_q);
          state_d = ST_SWAIT;
        end else begin
          state_d = ST_RSI;
        end
      end
      ST_SWAIT: begin
        if (div_done) begin
          dist_d  = sat_q16(neg_q, div_quot);
          state_d = ST_RSI;
        end
      end
      ST_RSI: begin
        if (cnt_q > CountW'(per_eff)) begin
          if (al_q == '0) begin
            rsi_d   = RSI_ONE;
            state_d = ST_EMIT;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = {ag_q, 16'h0000};
            div_req.den   = DivDW'(ag_q) + DivDW'(al_q);
            state_d       = ST_RWAIT;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_RWAIT: begin
        if (div_done) begin
          rsi_d   = div_quot[RsiW-1:0];
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hand over once the output register is free, then clear the series
        if (!out_valid_q || !out_stall_i) begin
          mom_out_d   = mom_q;
          rsi_out_d   = rsi_q;
          dist_out_d  = dist_q;
          out_valid_d = 1'b1;
          ptr_d       = '0;
          cnt_d       = '0;
          ag_d        = '0;
          al_d        = '0;
          prev_d      = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      cnt_q       <= '0;
      ag_q        <= '0;
      al_q        <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      lag_cfg_q   <= 6'd30;
      len_cfg_q   <= 7'd50;
      per_cfg_q   <= 6'd14;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      ag_q        <= ag_d;
      al_q        <= al_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MOM_LAG: lag_cfg_q <= cfg_data_i[5:0];
          CFG_SMA_LEN: len_cfg_q <= cfg_data_i;
          CFG_RSI_PER: per_cfg_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q        <= c_d;
    do_close_q <= do_close_d;
    last_q     <= last_d;
    seed_q     <= seed_d;
    neg_q      <= neg_d;
    k_q        <= k_d;
    sum_q      <= sum_d;
    mom_q      <= mom_d;
    rsi_q      <= rsi_d;
    dist_q     <= dist_d;
    mom_out_q  <= mom_out_d;
    rsi_out_q  <= rsi_out_d;
    dist_out_q <= dist_out_d;
  end

  pie_ram #(
    .WIDTH(PriceW),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ptr_q),
    .wdata_i(c_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  pie_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quot_o(div_quot)
  );

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign momentum_o     = mom_out_q;
  assign rsi_fraction_o = rsi_out_q;
  assign sma_distance_o = dist_out_q;
endmodule

@@ design/pie_ram.sv @@
// pie_ram: generic simple dual port ram with registered read
// no dependencies
module pie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ design/pie_div.sv @@
// pie_div: restoring divider, one quotient bit per cycle
// depends on pie_pkg for widths and the request struct
module pie_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pie_pkg::div_req_t        req_i,
  output logic                     done_o,
  output logic [pie_pkg::DivNW-1:0] quot_o
);
  import pie_pkg::*;

  localparam int CntW = $clog2(DivNW + 1);

  logic [DivNW-1:0] num_q, num_d;
  logic [DivDW-1:0] den_q, den_d;
  logic [DivDW-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DivDW:0]   rem_sh;
  logic             fits;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_sh = {rem_q, num_q[DivNW-1]};
    fits   = rem_sh >= {1'b0, den_q};
    if (req_i.start) begin
      num_d = req_i.num;
      den_d = req_i.den;
      rem_d = '0;
      cnt_d = CntW'(DivNW);
    end else if (cnt_q != '0) begin
      rem_d = fits ? DivDW'(rem_sh - {1'b0, den_q}) : rem_sh[DivDW-1:0];
      num_d = {num_q[DivNW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;
endmodule
